### rtl/prq_pkg.sv
// Shared types and constants for the priority ready queue.
package prq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PURGE   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] proc_id;
    logic [7:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_priority;
    logic [4:0] entry_count;
  } out_t;

  // One stored entry.
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } entry_t;

  // Access from the sequencer to the entry store.
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } store_req_t;

endpackage

### rtl/priority_ready_queue_top.sv
// Priority ready queue: sequencer, scan/compact loop and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | to block  | in_valid_i/in_stall_o | in_data_i  (prq_pkg::in_t)
//  out     | from block| out_valid_o/out_stall_i| out_data_o (prq_pkg::out_t)
//
//  Enqueue (stored or full), no-op and an empty dequeue go straight to DONE;
//  a purge on an empty queue passes through SCAN first. Dequeue and purge
//  walk the store through its single read port, one entry a cycle: a scan
//  over the entries held (a purge ends it after its match), then a close-up
//  pass that moves each later entry down one place.
//  Reset empties the queue at once (count cleared); the store needs no clear.
//  The output register holds a result while out_stall_i is high; the next
//  transaction may be taken meanwhile, and its result waits in DONE.
module priority_ready_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  prq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output prq_pkg::out_t out_data_o
);
  import prq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // captured transaction
  op_e        op_q, op_d;
  logic [7:0] pid_q, pid_d;

  // queue fill level
  logic [CntW-1:0] cnt_q, cnt_d;

  // read pointer and the tag of the entry in flight
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;

  // best / matching entry so far
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  entry_t          best_q, best_d;
  logic            found_q, found_d;
  status_e         st_q, st_d;

  logic       out_vld_q, out_vld_d;
  out_t       out_q, out_d;

  store_req_t req;
  entry_t     rdata;

  logic issue, take, match, out_free;

  prq_store u_store (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Dequeue keeps the strictly smaller priority, so ties stay with the earliest.
  assign take  = rd_vld_q && ((cmp_idx_q == '0) || (rdata.prio < best_q.prio));
  assign match = rd_vld_q && !found_q && (rdata.id == pid_q);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pid_d      = pid_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    cmp_idx_d  = rd_idx_q[IdxW-1:0];
    best_idx_d = best_idx_q;
    best_d     = best_q;
    found_d    = found_q;
    st_d       = st_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    issue      = 1'b0;

    req.we    = 1'b0;
    req.waddr = cnt_q[IdxW-1:0];
    req.wdata = '0;
    req.raddr = rd_idx_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(in_data_i.op);
          pid_d    = in_data_i.proc_id;
          rd_idx_d = '0;
          found_d  = 1'b0;
          best_d   = '0;
          best_idx_d = '0;
          st_d     = ST_OK;
          state_d  = S_DONE;
          case (op_e'(in_data_i.op))
            OP_ENQUEUE: begin
              if (cnt_q == CntW'(QueueDepth)) begin
                st_d = ST_FULL;
              end else begin
                req.we    = 1'b1;
                req.wdata = '{id: in_data_i.proc_id, prio: in_data_i.priority_req};
                cnt_d     = cnt_q + CntW'(1);
              end
            end
            OP_DEQUEUE: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_PURGE: state_d = S_SCAN;
            default:  st_d = ST_OK;
          endcase
        end
      end

      S_SCAN: begin
        if (op_q == OP_DEQUEUE) begin
          if (take) begin
            best_d     = rdata;
            best_idx_d = cmp_idx_q;
          end
          issue = (rd_idx_q < cnt_q);
        end else begin
          if (match) begin
            best_d     = rdata;
            best_idx_d = cmp_idx_q;
            found_d    = 1'b1;
          end
          issue = (rd_idx_q < cnt_q) && !found_q && !match;
        end
        if (issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (!rd_vld_q && (found_q || rd_idx_q == cnt_q)) begin
          if (op_q == OP_DEQUEUE || found_q) begin
            rd_idx_d = CntW'(best_idx_q) + CntW'(1);
            state_d  = S_SHIFT;
          end else begin
            st_d     = ST_NOT_FOUND;
            best_d   = '0;
            state_d  = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // read entry k+1, write the registered read data to k
        if (rd_idx_q < cnt_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rd_vld_q) begin
          req.we    = 1'b1;
          req.waddr = cmp_idx_q - IdxW'(1);
          req.wdata = rdata;
        end
        if (!rd_vld_q && rd_idx_q == cnt_q) begin
          cnt_d   = cnt_q - CntW'(1);
          st_d    = ST_OK;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_vld_d          = 1'b1;
          out_d.status       = st_q;
          out_d.out_id       = best_q.id;
          out_d.out_priority = best_q.prio;
          out_d.entry_count  = 5'(cnt_q);
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pid_q      <= pid_d;
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    st_q       <= st_d;
    out_q      <= out_d;
  end

endmodule

### rtl/prq_store.sv
// Entry store: one write port, one read port with registered read data.
module prq_store (
  input  logic               clk_i,
  input  prq_pkg::store_req_t req_i,
  output prq_pkg::entry_t    rdata_o
);
  import prq_pkg::*;

  entry_t mem [QueueDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### dv/tb_priority_ready_queue_top.sv
// Self-checking testbench for the priority ready queue top level.
module tb_priority_ready_queue_top;
  import prq_pkg::*;

  // Slowest correct run: ~1570 transactions, each at most a full dequeue scan and
  // close-up, plus idle gaps and stalls on both sides, plus one long hold-off.
  // The limit sits several times above that.
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned CalmTail    = 150;  // last transactions, no idling
  localparam int unsigned HoldAfter   = 500;  // long hold-off starts here
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned DrainWait   = 40;   // > worst dequeue latency

  typedef struct {
    in_t req;
    bit  drain_first;  // sender waits for all results before offering this one
  } stim_t;

  logic clk;
  logic rst_n = 1'b0;

  logic  in_valid  = 1'b0;
  in_t   in_data   = '0;
  logic  in_stall;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  stim_t pending_reqs[$];
  out_t  expected_results[$];

  // Shadow of the ready queue, in arrival order.
  entry_t shadow_entries[$];

  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned mismatches  = 0;
  bit          calm_tail   = 1'b0;
  bit          idle_allowed;

  priority_ready_queue_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idling runs in windows: every fourth window has none.
  assign idle_allowed = ((cycle_count / 300) % 4) != 0;

  // ---------------------------------------------------------------------------
  // Predictor: applies one transaction to the shadow queue and returns the
  // result the block must produce for it.
  // ---------------------------------------------------------------------------
  function automatic out_t serve_request(in_t req);
    out_t res;
    int   pick;
    res        = '0;
    res.status = ST_OK;
    case (req.op)
      OP_ENQUEUE: begin
        if (shadow_entries.size() >= QueueDepth) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries.push_back('{id: req.proc_id, prio: req.priority_req});
        end
      end
      OP_DEQUEUE: begin
        if (shadow_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // strict less-than keeps the earliest entry on a tie
          pick = 0;
          for (int k = 1; k < shadow_entries.size(); k++) begin
            if (shadow_entries[k].prio < shadow_entries[pick].prio) pick = k;
          end
          res.out_id       = shadow_entries[pick].id;
          res.out_priority = shadow_entries[pick].prio;
          shadow_entries.delete(pick);
        end
      end
      OP_PURGE: begin
        pick = -1;
        for (int k = 0; k < shadow_entries.size(); k++) begin
          if (pick < 0 && shadow_entries[k].id == req.proc_id) pick = k;
        end
        if (pick < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.out_id       = shadow_entries[pick].id;
          res.out_priority = shadow_entries[pick].prio;
          shadow_entries.delete(pick);
        end
      end
      default: ;  // no-op leaves everything as is
    endcase
    res.entry_count = 5'(shadow_entries.size());
    return res;
  endfunction

  task automatic queue_req(op_e op, logic [7:0] id, logic [7:0] pri, bit drain = 1'b0);
    stim_t s;
    s.req.op           = op;
    s.req.proc_id      = id;
    s.req.priority_req = pri;
    s.drain_first      = drain;
    pending_reqs.push_back(s);
  endtask

  // Mostly a small id pool so purges hit and duplicates occur.
  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Half the time a narrow range, which forces priority ties.
  function automatic logic [7:0] pick_prio();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned seq_len;
    bit          drain;
    bit          forced_drain;
    op_e         op;

    // Directed part: empty-queue cases, field extremes, duplicate ids,
    // tie on priority, purge of a missing id, no-op.
    queue_req(OP_DEQUEUE, 8'h00, 8'h00);   // empty dequeue
    queue_req(OP_PURGE,   8'h3C, 8'h00);   // purge on empty queue
    queue_req(OP_NOP,     8'hFF, 8'hFF);   // no-op on empty queue
    queue_req(OP_ENQUEUE, 8'h00, 8'hFF);
    queue_req(OP_ENQUEUE, 8'hFF, 8'h00);
    queue_req(OP_ENQUEUE, 8'hAA, 8'h55);
    queue_req(OP_ENQUEUE, 8'h55, 8'h55);   // same priority as the entry before
    queue_req(OP_ENQUEUE, 8'hAA, 8'h80);   // duplicate id
    queue_req(OP_NOP,     8'h12, 8'h34);
    queue_req(OP_PURGE,   8'hAA, 8'hFF);   // removes the first AA only
    queue_req(OP_DEQUEUE, 8'hFF, 8'hFF);   // lowest priority, 0x00
    queue_req(OP_DEQUEUE, 8'h00, 8'h00);   // 0x55 beats 0x80
    queue_req(OP_PURGE,   8'h77, 8'h00);   // no match in a non-empty queue
    queue_req(OP_DEQUEUE, 8'h00, 8'h00);
    queue_req(OP_DEQUEUE, 8'h00, 8'h00);
    queue_req(OP_DEQUEUE, 8'h00, 8'h00);   // empty again

    // Random part: fill-to-full runs, drain-to-empty runs and mixed traffic.
    forced_drain = 1'b0;
    while (pending_reqs.size() < RandomItems + 16) begin
      kind  = $urandom_range(0, 9);
      drain = ($urandom_range(0, 19) == 0);
      if (!forced_drain && pending_reqs.size() >= 800) begin
        drain        = 1'b1;
        forced_drain = 1'b1;
      end
      if (kind <= 1) begin
        seq_len = $urandom_range(17, 20);  // always runs into full
        for (int i = 0; i < seq_len; i++)
          queue_req(OP_ENQUEUE, pick_id(), pick_prio(), drain && i == 0);
      end else if (kind == 2) begin
        seq_len = $urandom_range(16, 18);
        for (int i = 0; i < seq_len; i++)
          queue_req(OP_DEQUEUE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    drain && i == 0);
      end else begin
        for (int i = 0; i < 24; i++) begin
          kind = $urandom_range(0, 19);
          if (kind < 9)       op = OP_ENQUEUE;
          else if (kind < 14) op = OP_DEQUEUE;
          else if (kind < 19) op = OP_PURGE;
          else                op = OP_NOP;
          queue_req(op, pick_id(), pick_prio(), drain && i == 0);
        end
      end
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Everything sent and every result back, then give the block time to
    // produce anything unexpected.
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers pending transactions; data holds while stalled.
  // ---------------------------------------------------------------------------
  int unsigned gap_left;

  always @(posedge clk or negedge rst_n) begin : drive_proc
    bit   took;
    logic next_valid;
    in_t  next_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left  = 0;
    end else begin
      took       = in_valid && !in_stall;
      next_valid = in_valid;
      next_data  = in_data;
      if (took) begin
        expected_results.push_back(serve_request(in_data));
        sent_count++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        calm_tail = pending_reqs.size() < CalmTail;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].drain_first && expected_results.size() != 0) begin
            // pause until the block has handed back every result
          end else if (!calm_tail && idle_allowed && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(0, 5);  // random burst of idle cycles
          end else begin
            next_valid = 1'b1;
            next_data  = pending_reqs.pop_front().req;
          end
        end
      end
      in_valid <= next_valid;
      in_data  <= next_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts plus one long hold-off so the block's
  // output and DONE slots fill and the input gets stalled.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;
  bit          long_hold_done;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      stall_left     = 0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && sent_count >= HoldAfter) begin
      long_hold_done = 1'b1;
      hold_left      = HoldCycles - 1;
      out_stall     <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm_tail && idle_allowed && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status",       want.status,       out_data.status);
        check_field("out_id",       want.out_id,       out_data.out_id);
        check_field("out_priority", want.out_priority, out_data.out_priority);
        check_field("entry_count",  want.entry_count,  out_data.entry_count);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
